// ===== design/aecp_pkg.sv =====
// Package for the escape parser: byte codes, mode and field codes, shared types.
package aecp_pkg;

  // Longest parameter run of a control sequence before a byte is forced final
  localparam int SEQ_MAX_LEN = 15;
  localparam int SEQ_LEN_W   = $clog2(SEQ_MAX_LEN + 1);
  localparam logic [SEQ_LEN_W-1:0] SEQ_LAST = SEQ_LEN_W'(SEQ_MAX_LEN);

  localparam int VALUE_W = 16;

  // Byte codes
  localparam logic [7:0] CH_ESC       = 8'h1B;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_DIGIT_LO  = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI  = 8'h39;
  localparam logic [7:0] CH_FINAL_LO  = 8'h40;
  localparam logic [7:0] CH_FINAL_HI  = 8'h7E;
  localparam logic [7:0] CH_CUP_H     = 8'h48;
  localparam logic [7:0] CH_CUP_F     = 8'h66;

  // Parser modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_ESCAPE = 2'd1;
  localparam logic [1:0] MODE_CSI    = 2'd2;

  // Parameter field phases
  localparam logic [1:0] PHASE_ROW  = 2'd0;
  localparam logic [1:0] PHASE_COL  = 2'd1;
  localparam logic [1:0] PHASE_STOP = 2'd2;

  // Result kinds
  localparam logic KIND_PRINT  = 1'b0;
  localparam logic KIND_CURSOR = 1'b1;

  // Control from the sequencer to the parameter decoder
  typedef struct packed {
    logic clear;  // start of a new control sequence
    logic step;   // feed one intermediate byte to the decoder
  } dec_ctrl_t;

endpackage

// ===== design/aecp_if.sv =====
// Channel interfaces: terminal byte input and parser result output.
interface aecp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface aecp_result_if import aecp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         char_code;
  logic [VALUE_W-1:0] row;
  logic [VALUE_W-1:0] col;

  modport source (output valid, output kind, output char_code, output row, output col,
                  input ready);
  modport sink   (input valid, input kind, input char_code, input row, input col,
                  output ready);
endinterface

// ===== design/aecp_param_dec.sv =====
// Row/column parameter decoder for cursor-position control sequences.
module aecp_param_dec import aecp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dec_ctrl_t          ctrl,
  input  logic [7:0]         byte_in,
  output logic [VALUE_W-1:0] row_val,
  output logic [VALUE_W-1:0] col_val
);

  logic [1:0]         phase;
  logic [VALUE_W-1:0] row_acc;
  logic [VALUE_W-1:0] col_acc;
  logic               row_seen;
  logic               col_seen;

  logic               is_digit;
  logic [3:0]         digit;
  logic [VALUE_W-1:0] row_acc_next;
  logic [VALUE_W-1:0] col_acc_next;

  // acc * 10 + digit, saturating at the top of the field range
  function automatic logic [VALUE_W-1:0] add_digit(input logic [VALUE_W-1:0] acc,
                                                   input logic [3:0] d);
    logic [VALUE_W+3:0] sum;
    sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{VALUE_W{1'b0}}, d};
    if (sum[VALUE_W+3:VALUE_W] != '0) begin
      return '1;
    end
    return sum[VALUE_W-1:0];
  endfunction

  assign is_digit     = (byte_in >= CH_DIGIT_LO) && (byte_in <= CH_DIGIT_HI);
  assign digit        = byte_in[3:0];
  assign row_acc_next = add_digit(row_acc, digit);
  assign col_acc_next = add_digit(col_acc, digit);

  // Missing values report 1
  assign row_val = row_seen ? row_acc : VALUE_W'(1);
  assign col_val = col_seen ? col_acc : VALUE_W'(1);

  // Field state update
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      phase    <= PHASE_ROW;
      row_acc  <= '0;
      col_acc  <= '0;
      row_seen <= 1'b0;
      col_seen <= 1'b0;
    end else if (ctrl.step) begin
      case (phase)
        PHASE_ROW: begin
          if (is_digit) begin
            row_acc  <= row_acc_next;
            row_seen <= 1'b1;
          end else if (byte_in == CH_SEMI) begin
            phase <= PHASE_COL;
          end else begin
            phase <= PHASE_STOP;
          end
        end
        PHASE_COL: begin
          if (is_digit) begin
            col_acc  <= col_acc_next;
            col_seen <= 1'b1;
          end else begin
            phase <= PHASE_STOP;
          end
        end
        default: begin
          phase <= phase;
        end
      endcase
    end
  end

endmodule

// ===== design/ansi_escape_cursor_parser.sv =====
// Top level of the VT100/ANSI escape parser with cursor-position decoding.
//
// Channels: src carries one terminal byte per transaction (valid/ready);
// dst carries at most one result per byte: a print character (kind 0,
// char_code set, row/col zero) or a set-cursor command (kind 1, row and
// col decoded from "row;col", each defaulting to 1, saturating at 65535).
// ESC followed by '[' opens a control sequence; 'H' or 'f' as its final
// byte yields a cursor result, other final bytes yield nothing. A sequence
// is forced to end after SEQ_MAX_LEN parameter bytes.
// Latency: a result appears on dst the cycle after its byte is accepted.
// Throughput: one byte per cycle; the mode update, the decimal digit
// accumulate (shift-add by ten) and the result register all update on
// the same clock edge, so a byte is taken whenever the result register is
// empty or is being emptied in the same cycle.
// Stall: when dst is held off with a result pending, src.ready drops and
// the parser state holds until the result is taken.
// Reset (rst, synchronous): parser returns to idle, no result pending.
module ansi_escape_cursor_parser import aecp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  aecp_byte_if.sink     src,
  aecp_result_if.source dst
);

  logic [1:0]           mode;
  logic [SEQ_LEN_W-1:0] seq_length;

  logic                 accept;
  logic                 is_final;
  logic                 is_cup;
  logic                 emit;
  logic                 emit_kind;
  logic [1:0]           mode_next;
  dec_ctrl_t            dec_ctrl;
  logic [VALUE_W-1:0]   row_val;
  logic [VALUE_W-1:0]   col_val;

  logic                 out_valid;
  logic                 out_kind;
  logic [7:0]           out_char;
  logic [VALUE_W-1:0]   out_row;
  logic [VALUE_W-1:0]   out_col;

  assign src.ready = !out_valid || dst.ready;
  assign accept    = src.valid && src.ready;

  assign is_final = ((src.byte_in >= CH_FINAL_LO) && (src.byte_in <= CH_FINAL_HI)) ||
                    (seq_length >= SEQ_LAST);
  assign is_cup   = (src.byte_in == CH_CUP_H) || (src.byte_in == CH_CUP_F);

  // Per-byte mode sequencing
  always_comb begin
    mode_next      = mode;
    emit           = 1'b0;
    emit_kind      = KIND_PRINT;
    dec_ctrl.clear = 1'b0;
    dec_ctrl.step  = 1'b0;
    case (mode)
      MODE_ESCAPE: begin
        if (src.byte_in == CH_LBRACKET) begin
          mode_next      = MODE_CSI;
          dec_ctrl.clear = accept;
        end else begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_CSI: begin
        if (!is_final) begin
          dec_ctrl.step = accept;
        end else begin
          mode_next = MODE_IDLE;
          emit      = is_cup;
          emit_kind = KIND_CURSOR;
        end
      end
      default: begin
        if (src.byte_in == CH_ESC) begin
          mode_next = MODE_ESCAPE;
        end else begin
          emit = 1'b1;
        end
      end
    endcase
  end

  // Mode and sequence length
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      seq_length <= '0;
    end else if (accept) begin
      mode <= mode_next;
      if (dec_ctrl.clear) begin
        seq_length <= '0;
      end else if (dec_ctrl.step) begin
        seq_length <= seq_length + SEQ_LEN_W'(1);
      end
    end
  end

  aecp_param_dec u_param_dec (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (dec_ctrl),
    .byte_in (src.byte_in),
    .row_val (row_val),
    .col_val (col_val)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (dst.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind <= emit_kind;
      if (emit_kind == KIND_CURSOR) begin
        out_char <= '0;
        out_row  <= row_val;
        out_col  <= col_val;
      end else begin
        out_char <= src.byte_in;
        out_row  <= '0;
        out_col  <= '0;
      end
    end
  end

  assign dst.valid     = out_valid;
  assign dst.kind      = out_kind;
  assign dst.char_code = out_char;
  assign dst.row       = out_row;
  assign dst.col       = out_col;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for the escape parser: directed byte table, then random terminal streams.
module testbench;
  import aecp_pkg::*;

  typedef struct packed {
    logic               kind;
    logic [7:0]         char_code;
    logic [VALUE_W-1:0] row;
    logic [VALUE_W-1:0] col;
  } parser_result_t;

  // How a table row gets its expectation
  typedef enum logic [1:0] {
    EXP_PREDICT,  // from the parser model below
    EXP_RESULT,   // typed result in the row
    EXP_NONE      // typed: no result
  } expect_src_t;

  typedef struct packed {
    logic [7:0]     data;
    expect_src_t    how;
    parser_result_t res;
  } step_row_t;

  localparam int RANDOM_BYTES = 2000;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_LIMIT  = 1000;
  localparam int SETTLE_TICKS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aecp_byte_if   byte_ch ();
  aecp_result_if result_ch ();

  ansi_escape_cursor_parser dut (
    .clk (clk),
    .rst (rst),
    .src (byte_ch),
    .dst (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  parser_result_t pending_results[$];
  step_row_t      directed_table[$];
  int             fault_count = 0;
  int             bytes_sent  = 0;
  bit             steady      = 1'b0;  // no idling on either side while set

  // Parser model state
  logic [1:0]           m_mode      = MODE_IDLE;
  logic [SEQ_LEN_W-1:0] m_len       = '0;
  logic [VALUE_W-1:0]   m_row       = '0;
  logic [VALUE_W-1:0]   m_col       = '0;
  logic                 m_row_seen  = 1'b0;
  logic                 m_col_seen  = 1'b0;
  logic [1:0]           m_phase     = PHASE_ROW;

  function automatic parser_result_t print_of(input logic [7:0] ch);
    parser_result_t r;
    r           = '0;
    r.kind      = KIND_PRINT;
    r.char_code = ch;
    return r;
  endfunction

  function automatic parser_result_t cursor_of(input logic [VALUE_W-1:0] row,
                                               input logic [VALUE_W-1:0] col);
    parser_result_t r;
    r      = '0;
    r.kind = KIND_CURSOR;
    r.row  = row;
    r.col  = col;
    return r;
  endfunction

  // Decimal accumulate, clamped at the field's maximum
  function automatic logic [VALUE_W-1:0] add_decimal(input logic [VALUE_W-1:0] acc,
                                                     input logic [7:0] ch);
    logic [31:0] v;
    v = 32'(acc) * 32'd10 + 32'(ch - CH_DIGIT_LO);
    return (v > 32'hFFFF) ? 16'hFFFF : v[VALUE_W-1:0];
  endfunction

  // Advance the parser model by one byte; returns 1 when a result comes out
  function automatic bit parse_byte(input logic [7:0] b, output parser_result_t res);
    logic is_final;
    logic is_digit;
    res      = '0;
    is_digit = (b >= CH_DIGIT_LO) && (b <= CH_DIGIT_HI);
    case (m_mode)
      MODE_ESCAPE: begin
        if (b == CH_LBRACKET) begin
          m_mode     = MODE_CSI;
          m_len      = '0;
          m_row      = '0;
          m_col      = '0;
          m_row_seen = 1'b0;
          m_col_seen = 1'b0;
          m_phase    = PHASE_ROW;
        end else begin
          m_mode = MODE_IDLE;
        end
        return 1'b0;
      end
      MODE_CSI: begin
        is_final = ((b >= CH_FINAL_LO) && (b <= CH_FINAL_HI)) || (m_len >= SEQ_LAST);
        if (!is_final) begin
          // parameter decode: row digits, one ';', column digits, else stop
          if (m_phase == PHASE_ROW) begin
            if (is_digit) begin
              m_row      = add_decimal(m_row, b);
              m_row_seen = 1'b1;
            end else if (b == CH_SEMI) begin
              m_phase = PHASE_COL;
            end else begin
              m_phase = PHASE_STOP;
            end
          end else if (m_phase == PHASE_COL) begin
            if (is_digit) begin
              m_col      = add_decimal(m_col, b);
              m_col_seen = 1'b1;
            end else begin
              m_phase = PHASE_STOP;
            end
          end
          m_len = m_len + SEQ_LEN_W'(1);
          return 1'b0;
        end
        m_mode = MODE_IDLE;
        if ((b == CH_CUP_H) || (b == CH_CUP_F)) begin
          res = cursor_of(m_row_seen ? m_row : 16'd1, m_col_seen ? m_col : 16'd1);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        if (b == CH_ESC) begin
          m_mode = MODE_ESCAPE;
          return 1'b0;
        end
        res = print_of(b);
        return 1'b1;
      end
    endcase
  endfunction

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  // Offer one byte after a random gap, wait for the transaction, record the expectation
  task automatic send_byte(input logic [7:0] b, input expect_src_t how = EXP_PREDICT,
                           input parser_result_t typed = '0);
    int             gap;
    bit             has;
    parser_result_t predicted;
    gap = steady ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      byte_ch.valid <= 1'b0;
    end
    @(negedge clk);
    byte_ch.valid   <= 1'b1;
    byte_ch.byte_in <= b;
    do @(posedge clk); while (!byte_ch.ready);
    has = parse_byte(b, predicted);
    case (how)
      EXP_RESULT: pending_results.push_back(typed);
      EXP_NONE:   ;
      default:    if (has) pending_results.push_back(predicted);
    endcase
    bytes_sent++;
  endtask

  function automatic logic [7:0] random_mid_byte();
    int r;
    // bytes that never end a sequence by themselves: 0x00..0x3F, 0x7F..0xFF
    r = $urandom_range(0, 192);
    return (r < 64) ? 8'(r) : 8'(r + 63);
  endfunction

  task automatic send_digits(input int n);
    repeat (n) send_byte(8'(CH_DIGIT_LO + $urandom_range(0, 9)));
  endtask

  task automatic send_random_group();
    int sel;
    int r;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 29) == 0) steady = !steady;
    if (sel < 65) begin
      // control sequence with random content
      send_byte(CH_ESC);
      send_byte(CH_LBRACKET);
      if ($urandom_range(0, 9) == 0) begin
        // long run that may reach the length limit
        repeat ($urandom_range(12, 20)) send_byte(random_mid_byte());
        if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(0, 255)));
        else send_byte($urandom_range(0, 1) ? CH_CUP_H : CH_CUP_F);
      end else begin
        send_digits($urandom_range(0, 6));
        if ($urandom_range(0, 4) != 0) send_byte(CH_SEMI);
        send_digits($urandom_range(0, 6));
        if ($urandom_range(0, 4) == 0) begin
          send_byte(random_mid_byte());
          send_digits($urandom_range(0, 2));
        end
        r = $urandom_range(0, 9);
        if (r < 4) send_byte(CH_CUP_H);
        else if (r < 8) send_byte(CH_CUP_F);
        else send_byte(8'($urandom_range(CH_FINAL_LO, CH_FINAL_HI)));
      end
    end else if (sel < 85) begin
      // random byte stream
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      // escape followed by another escape or a random byte
      send_byte(CH_ESC);
      send_byte(($urandom_range(0, 3) == 0) ? CH_ESC : 8'($urandom_range(0, 255)));
    end
  endtask

  // Result side: random hold-off per result
  initial begin
    int gap;
    result_ch.ready = 1'b0;
    forever begin
      gap = steady ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
      end
      @(negedge clk);
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && !rst));
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    parser_result_t exp_res;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        note_fault($sformatf("unexpected result kind=%0d char=%02h row=%0d col=%0d",
                             result_ch.kind, result_ch.char_code, result_ch.row,
                             result_ch.col));
      end else begin
        exp_res = pending_results.pop_front();
        if (result_ch.kind !== exp_res.kind)
          note_fault($sformatf("kind: expected %0d, got %0d", exp_res.kind, result_ch.kind));
        if (result_ch.char_code !== exp_res.char_code)
          note_fault($sformatf("char_code: expected %02h, got %02h", exp_res.char_code,
                               result_ch.char_code));
        if (result_ch.row !== exp_res.row)
          note_fault($sformatf("row: expected %0d, got %0d", exp_res.row, result_ch.row));
        if (result_ch.col !== exp_res.col)
          note_fault($sformatf("col: expected %0d, got %0d", exp_res.col, result_ch.col));
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int guard;
    byte_ch.valid   = 1'b0;
    byte_ch.byte_in = 8'h00;

    // byte extremes, empty parameters, saturation, escape drops,
    // ESC inside a sequence, and a final byte with no result
    directed_table.push_back('{8'h00,       EXP_RESULT,  print_of(8'h00)});
    directed_table.push_back('{8'hFF,       EXP_RESULT,  print_of(8'hFF)});
    directed_table.push_back('{CH_ESC,      EXP_NONE,    '0});
    directed_table.push_back('{CH_LBRACKET, EXP_NONE,    '0});
    directed_table.push_back('{CH_CUP_H,    EXP_RESULT,  cursor_of(16'd1, 16'd1)});
    directed_table.push_back('{CH_ESC,      EXP_NONE,    '0});
    directed_table.push_back('{CH_LBRACKET, EXP_NONE,    '0});
    directed_table.push_back('{"7",         EXP_NONE,    '0});
    directed_table.push_back('{"0",         EXP_NONE,    '0});
    directed_table.push_back('{"0",         EXP_NONE,    '0});
    directed_table.push_back('{"0",         EXP_NONE,    '0});
    directed_table.push_back('{"0",         EXP_NONE,    '0});
    directed_table.push_back('{CH_SEMI,     EXP_NONE,    '0});
    directed_table.push_back('{"0",         EXP_NONE,    '0});
    directed_table.push_back('{CH_CUP_F,    EXP_RESULT,  cursor_of(16'd65535, 16'd0)});
    directed_table.push_back('{CH_ESC,      EXP_NONE,    '0});
    directed_table.push_back('{CH_ESC,      EXP_NONE,    '0});
    directed_table.push_back('{CH_LBRACKET, EXP_RESULT,  print_of(CH_LBRACKET)});
    directed_table.push_back('{CH_ESC,      EXP_NONE,    '0});
    directed_table.push_back('{"x",         EXP_NONE,    '0});
    directed_table.push_back('{CH_ESC,      EXP_PREDICT, '0});
    directed_table.push_back('{CH_LBRACKET, EXP_PREDICT, '0});
    directed_table.push_back('{CH_SEMI,     EXP_PREDICT, '0});
    directed_table.push_back('{"5",         EXP_PREDICT, '0});
    directed_table.push_back('{CH_ESC,      EXP_PREDICT, '0});
    directed_table.push_back('{"9",         EXP_PREDICT, '0});
    directed_table.push_back('{CH_CUP_H,    EXP_PREDICT, '0});
    directed_table.push_back('{CH_ESC,      EXP_NONE,    '0});
    directed_table.push_back('{CH_LBRACKET, EXP_NONE,    '0});
    directed_table.push_back('{"-",         EXP_NONE,    '0});
    directed_table.push_back('{"m",         EXP_NONE,    '0});

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_table[i])
      send_byte(directed_table[i].data, directed_table[i].how, directed_table[i].res);

    while (bytes_sent < RANDOM_BYTES + directed_table.size())
      send_random_group();

    @(negedge clk);
    byte_ch.valid <= 1'b0;

    // drain outstanding results, then a short settle
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_TICKS) @(posedge clk);
    if (pending_results.size() != 0)
      note_fault($sformatf("%0d expected results never arrived", pending_results.size()));

    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
design/aecp_pkg.sv
design/aecp_if.sv
design/aecp_param_dec.sv
design/ansi_escape_cursor_parser.sv
bench/testbench.sv
